[src/sshs_pkg.sv]
// ----------------------------------------------------------------------------
// sshs_pkg
// Shared types and constants for the servo seek/hold slew controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sshs_pkg;

  localparam int PW = 12;  // pulse width field, microseconds
  localparam int TW = 32;  // millisecond timestamp
  localparam int RW = 16;  // random sample
  localparam int HW = 16;  // hold time register
  localparam int IW = 2;   // configuration register index

  localparam int DELTA_LIMIT_DEF = 10;
  localparam int SAFETY_MIN_DEF  = 500;
  localparam int SAFETY_MAX_DEF  = 2500;

  localparam logic [PW-1:0] RANGE_MIN_RST = 12'd1000;
  localparam logic [PW-1:0] RANGE_MAX_RST = 12'd2000;
  localparam logic [HW-1:0] HOLD_MS_RST   = 16'd1000;
  localparam logic [PW-1:0] PULSE_RST     = 12'd1500;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_RUN        = 3'd1,
    OP_RUN_MANUAL = 3'd2,
    OP_STOP       = 3'd3,
    OP_SET_TARGET = 3'd4,
    OP_RECENTER   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    MODE_SEEK   = 2'd0,
    MODE_HOLD   = 2'd1,
    MODE_MANUAL = 2'd2
  } mode_t;

  typedef enum logic [IW-1:0] {
    CFG_RANGE_MIN = 2'd0,
    CFG_RANGE_MAX = 2'd1,
    CFG_HOLD_MS   = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

[src/servo_seek_hold_slew_controller.sv]
// ----------------------------------------------------------------------------
// servo_seek_hold_slew_controller
// Command-driven servo pulse sequencer: slew-limited seek, timed hold with a
// new random target, manual stepping, run/stop/recenter control.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------------
//  cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in  | in_valid / in_ready   | in_op, in_now_ms, in_rand_value,
//          |     |                       | in_manual_target
//  out     | out | out_valid / out_ready | out_pulse_us, out_pulse_written,
//          |     |                       | out_drive_enable, out_is_running,
//          |     |                       | out_target_us, out_mode
//
//  Every input transaction yields exactly one output transaction: it is held
//  in the command register, then passes through the update logic into the
//  result register. Throughput is one transaction per cycle while the output
//  side is not stalled; the controller state is updated in the same edge
//  that loads the result register, so back-to-back commands see each other's
//  effects. An output stall backs up into the command register and then drops
//  in_ready. cfg_ready is always high.
//  rst_n is synchronous, active low; it clears the pipeline valids, the
//  controller state and the range/hold registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_seek_hold_slew_controller #(
  parameter int DELTA_LIMIT = sshs_pkg::DELTA_LIMIT_DEF,
  parameter int SAFETY_MIN  = sshs_pkg::SAFETY_MIN_DEF,
  parameter int SAFETY_MAX  = sshs_pkg::SAFETY_MAX_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    cfg_valid,
  output      logic                    cfg_ready,
  input  wire logic [sshs_pkg::IW-1:0] cfg_index,
  input  wire logic [sshs_pkg::HW-1:0] cfg_data,

  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [2:0]              in_op,
  input  wire logic [sshs_pkg::TW-1:0] in_now_ms,
  input  wire logic [sshs_pkg::RW-1:0] in_rand_value,
  input  wire logic [sshs_pkg::PW-1:0] in_manual_target,

  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [sshs_pkg::PW-1:0] out_pulse_us,
  output      logic                    out_pulse_written,
  output      logic                    out_drive_enable,
  output      logic                    out_is_running,
  output      logic [sshs_pkg::PW-1:0] out_target_us,
  output      logic [1:0]              out_mode
);

  import sshs_pkg::*;

  localparam logic [PW-1:0] DLIM  = PW'(DELTA_LIMIT);
  localparam logic [PW-1:0] S_MIN = PW'(SAFETY_MIN);
  localparam logic [PW-1:0] S_MAX = PW'(SAFETY_MAX);

  // --------------------------------------------------------------------------
  // Configuration registers (on write, range_min is floored at the safety minimum and range_max capped at the maximum)
  // --------------------------------------------------------------------------
  logic [PW-1:0] range_min_r, range_max_r;
  logic [HW-1:0] hold_ms_r;
  logic [PW-1:0] cfg_val12;

  assign cfg_ready = 1'b1;
  assign cfg_val12 = cfg_data[PW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= RANGE_MIN_RST;
      range_max_r <= RANGE_MAX_RST;
      hold_ms_r   <= HOLD_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RANGE_MIN: range_min_r <= (cfg_val12 < S_MIN) ? S_MIN : cfg_val12;
        CFG_RANGE_MAX: range_max_r <= (cfg_val12 > S_MAX) ? S_MAX : cfg_val12;
        CFG_HOLD_MS:   hold_ms_r   <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: command register -> result register
  // --------------------------------------------------------------------------
  logic cmd_vld_r, out_vld_r;
  logic out_free, cmd_go;

  assign out_free = !out_vld_r || out_ready;
  assign cmd_go   = cmd_vld_r && out_free;
  assign in_ready = !cmd_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) cmd_vld_r <= in_valid;
      if (out_free) out_vld_r <= cmd_vld_r;
    end
  end

  // command payload register
  logic [2:0]    op_r;
  logic [TW-1:0] now_r;
  logic [RW-1:0] rand_r;
  logic [PW-1:0] req_r;

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_r   <= in_op;
      now_r  <= in_now_ms;
      rand_r <= in_rand_value;
      req_r  <= in_manual_target;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  logic [PW-1:0] pulse_r, pulse_nxt;
  logic [PW-1:0] goal_r, goal_nxt;
  mode_t         mode_r, mode_nxt;
  logic          run_r, run_nxt;
  logic          att_r, att_nxt;
  logic [TW-1:0] hold_t0_r, hold_t0_nxt;
  logic          wrote;

  // slew step toward the goal; lands between pulse and goal, so never wraps
  logic [PW-1:0] up_gap, dn_gap, step_pulse;
  assign up_gap = goal_r - pulse_r;
  assign dn_gap = pulse_r - goal_r;
  always_comb begin
    if (goal_r > pulse_r)
      step_pulse = pulse_r + ((up_gap > DLIM) ? DLIM : up_gap);
    else
      step_pulse = pulse_r - ((dn_gap > DLIM) ? DLIM : dn_gap);
  end

  // new random target: range_min + (rand * span) >> 16, 16x12 product
  logic [PW-1:0]    span;
  logic [RW+PW-1:0] prod;
  logic [PW-1:0]    pick;
  assign span = range_max_r - range_min_r;
  assign prod = (RW+PW)'(rand_r) * (RW+PW)'(span);
  assign pick = (range_max_r <= range_min_r) ? range_min_r
              : range_min_r + prod[RW+PW-1:RW];

  // hold timeout, wrapping elapsed time
  logic [TW-1:0] elapsed;
  logic          hold_done;
  assign elapsed   = now_r - hold_t0_r;
  assign hold_done = elapsed > TW'(hold_ms_r);

  logic [PW:0]   mid_sum;
  logic [PW-1:0] req_clamp;
  assign mid_sum   = {1'b0, range_min_r} + {1'b0, range_max_r};
  assign req_clamp = (req_r < S_MIN) ? S_MIN : ((req_r > S_MAX) ? S_MAX : req_r);

  always_comb begin
    pulse_nxt   = pulse_r;
    goal_nxt    = goal_r;
    mode_nxt    = mode_r;
    run_nxt     = run_r;
    att_nxt     = att_r;
    hold_t0_nxt = hold_t0_r;
    wrote       = 1'b0;
    case (op_r)
      OP_TICK: begin
        if (run_r) begin
          case (mode_r)
            MODE_SEEK: begin
              if (pulse_r == goal_r) begin
                // arrived: start the hold window and release the drive
                mode_nxt    = MODE_HOLD;
                hold_t0_nxt = now_r;
                att_nxt     = 1'b0;
              end else begin
                pulse_nxt = step_pulse;
                wrote     = 1'b1;
              end
            end
            MODE_MANUAL: begin
              if (pulse_r != goal_r) begin
                pulse_nxt = step_pulse;
                wrote     = 1'b1;
              end
            end
            MODE_HOLD: begin
              if (hold_done) begin
                mode_nxt = MODE_SEEK;
                goal_nxt = pick;
                att_nxt  = 1'b1;
              end
            end
            default: mode_nxt = MODE_HOLD;
          endcase
        end
      end
      OP_RUN, OP_RUN_MANUAL: begin
        att_nxt  = 1'b1;
        wrote    = 1'b1;
        run_nxt  = 1'b1;
        mode_nxt = (op_r == OP_RUN) ? MODE_HOLD : MODE_MANUAL;
      end
      OP_STOP: begin
        att_nxt  = 1'b0;
        run_nxt  = 1'b0;
        mode_nxt = MODE_HOLD;
      end
      OP_SET_TARGET: begin
        goal_nxt = req_clamp;
        mode_nxt = MODE_MANUAL;
      end
      OP_RECENTER: begin
        pulse_nxt = mid_sum[PW:1];
        goal_nxt  = mid_sum[PW:1];
        run_nxt   = 1'b0;
        mode_nxt  = MODE_SEEK;
      end
      default: ;  // undefined command, state untouched
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r   <= PULSE_RST;
      goal_r    <= PULSE_RST;
      mode_r    <= MODE_SEEK;
      run_r     <= 1'b0;
      att_r     <= 1'b0;
      hold_t0_r <= '0;
    end else if (cmd_go) begin
      pulse_r   <= pulse_nxt;
      goal_r    <= goal_nxt;
      mode_r    <= mode_nxt;
      run_r     <= run_nxt;
      att_r     <= att_nxt;
      hold_t0_r <= hold_t0_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [PW-1:0] res_pulse_r, res_goal_r;
  logic          res_wrote_r, res_att_r, res_run_r;
  mode_t         res_mode_r;

  always_ff @(posedge clk) begin
    if (cmd_go) begin
      res_pulse_r <= pulse_nxt;
      res_wrote_r <= wrote;
      res_att_r   <= att_nxt;
      res_run_r   <= run_nxt;
      res_goal_r  <= goal_nxt;
      res_mode_r  <= mode_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_pulse_us      = res_pulse_r;
  assign out_pulse_written = res_wrote_r;
  assign out_drive_enable  = res_att_r;
  assign out_is_running    = res_run_r;
  assign out_target_us     = res_goal_r;
  assign out_mode          = res_mode_r;

endmodule

`default_nettype wire
